@@ rtl/mcf_pkg.sv @@
package mcf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SIZE_W      = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int TCNT_W      = SIZE_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // filter modes
    localparam logic [3:0] MODE_GREY    = 4'd0;
    localparam logic [3:0] MODE_BDILATE = 4'd1;
    localparam logic [3:0] MODE_BERODE  = 4'd2;
    localparam logic [3:0] MODE_MIN     = 4'd3;
    localparam logic [3:0] MODE_MAX     = 4'd4;
    localparam logic [3:0] MODE_OPEN    = 4'd5;
    localparam logic [3:0] MODE_CLOSE   = 4'd6;
    localparam logic [3:0] MODE_OUTER   = 4'd7;
    localparam logic [3:0] MODE_INNER   = 4'd8;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [3:0]        mode;
    } cfg_t;

    // image border flags of one window position
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } bnd_t;

    // one tick handed from the front end to the window pipeline
    typedef struct packed {
        logic [7:0]       grey;
        logic [COL_W-1:0] tcol;
        logic [3:0]       mode;
        bnd_t             mid_bnd;
        bnd_t             out_bnd;
        logic             out_ok;
        logic             last;
    } tok_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    // taps are row-major: k = 3*row + col
    function automatic logic [8:0] win_mask(input bnd_t b);
        logic [8:0] m;
        m = '1;
        if (b.top)   m = m & 9'b111_111_000;
        if (b.bot)   m = m & 9'b000_111_111;
        if (b.left)  m = m & 9'b110_110_110;
        if (b.right) m = m & 9'b011_011_011;
        return m;
    endfunction

    function automatic logic [7:0] win_lo(input logic [8:0][7:0] w, input logic [8:0] m);
        logic [7:0] v;
        v = 8'hFF;
        for (int k = 0; k < 9; k++) begin
            if (m[k] && (w[k] < v)) v = w[k];
        end
        return v;
    endfunction

    function automatic logic [7:0] win_hi(input logic [8:0][7:0] w, input logic [8:0] m);
        logic [7:0] v;
        v = 8'h00;
        for (int k = 0; k < 9; k++) begin
            if (m[k] && (w[k] > v)) v = w[k];
        end
        return v;
    endfunction

endpackage

@@ rtl/mcf_front.sv @@
module mcf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc,
    input  logic                action,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  mcf_pkg::cfg_t       cfg,
    output logic                push,
    output mcf_pkg::tok_t       tok
);

    logic                        frame_on_reg, frame_on_next;
    logic [mcf_pkg::SIZE_W-1:0]  w_reg, h_reg;
    logic [3:0]                  mode_reg;
    logic [mcf_pkg::COL_W-1:0]   icol_reg, icol_next, mcol_reg, mcol_next, ocol_reg, ocol_next;
    logic [mcf_pkg::ROW_W-1:0]   irow_reg, irow_next, mrow_reg, mrow_next, orow_reg, orow_next;
    logic                        in_done_reg, in_done_next;
    logic                        m_on_reg, m_on_next, o_on_reg, o_on_next;
    logic [mcf_pkg::TCNT_W-1:0]  tcnt_reg, tcnt_next;

    logic                        start, tick;
    logic [mcf_pkg::SIZE_W-1:0]  cw, ch, wm1, hm1, cfg_w, cfg_h;
    logic [3:0]                  cmode;
    logic [mcf_pkg::COL_W-1:0]   cicol, cmcol, cocol;
    logic [mcf_pkg::ROW_W-1:0]   cirow, cmrow, corow;
    logic                        cdone, cm_on, co_on;
    logic [mcf_pkg::TCNT_W-1:0]  ctcnt, d1, d2;
    logic                        i_eol, i_last, m_ok, m_eol, m_last, o_ok, o_eol, o_last;
    logic [23:0]                 gsum;

    // size clamping
    always_comb
    begin
        cfg_w = cfg.width;
        if (cfg.width == '0)
            cfg_w = mcf_pkg::SIZE_W'(1);
        else if (cfg.width > mcf_pkg::SIZE_W'(mcf_pkg::MAX_WIDTH))
            cfg_w = mcf_pkg::SIZE_W'(mcf_pkg::MAX_WIDTH);
        cfg_h = cfg.height;
        if (cfg.height == '0)
            cfg_h = mcf_pkg::SIZE_W'(1);
        else if (cfg.height > mcf_pkg::SIZE_W'(mcf_pkg::MAX_HEIGHT))
            cfg_h = mcf_pkg::SIZE_W'(mcf_pkg::MAX_HEIGHT);
    end

    // grey conversion
    assign gsum = 24'(red) * 24'd19595 + 24'(green) * 24'd38470 + 24'(blue) * 24'd7471;

    // frame start and tick qualification
    assign start = acc && !frame_on_reg && !action;
    assign tick  = acc && (frame_on_reg ? (in_done_reg || !action) : !action);

    // current state, fresh at frame start
    always_comb
    begin
        cw    = start ? cfg_w    : w_reg;
        ch    = start ? cfg_h    : h_reg;
        cmode = start ? cfg.mode : mode_reg;
        cicol = start ? '0 : icol_reg;
        cirow = start ? '0 : irow_reg;
        cmcol = start ? '0 : mcol_reg;
        cmrow = start ? '0 : mrow_reg;
        cocol = start ? '0 : ocol_reg;
        corow = start ? '0 : orow_reg;
        cdone = start ? 1'b0 : in_done_reg;
        cm_on = start ? 1'b0 : m_on_reg;
        co_on = start ? 1'b0 : o_on_reg;
        ctcnt = start ? '0 : tcnt_reg;
    end

    assign wm1 = cw - mcf_pkg::SIZE_W'(1);
    assign hm1 = ch - mcf_pkg::SIZE_W'(1);
    assign d1  = mcf_pkg::TCNT_W'(cw) + mcf_pkg::TCNT_W'(1);
    assign d2  = {d1[mcf_pkg::TCNT_W-2:0], 1'b0};

    // position counters of the three stages
    always_comb
    begin
        i_eol  = {1'b0, cicol} == wm1;
        i_last = i_eol && ({1'b0, cirow} == hm1);
        m_ok   = cm_on || (ctcnt == d1);
        m_eol  = {1'b0, cmcol} == wm1;
        m_last = m_eol && ({1'b0, cmrow} == hm1);
        o_ok   = co_on || (ctcnt == d2);
        o_eol  = {1'b0, cocol} == wm1;
        o_last = o_eol && ({1'b0, corow} == hm1);

        icol_next    = i_eol ? '0 : cicol + 1'b1;
        irow_next    = (i_eol && !cdone) ? cirow + 1'b1 : cirow;
        in_done_next = cdone || i_last;

        mcol_next = cmcol;
        mrow_next = cmrow;
        m_on_next = 1'b0;
        if (m_ok)
        begin
            mcol_next = m_eol ? '0 : cmcol + 1'b1;
            mrow_next = m_eol ? cmrow + 1'b1 : cmrow;
            m_on_next = !m_last;
        end

        ocol_next     = cocol;
        orow_next     = corow;
        o_on_next     = 1'b0;
        frame_on_next = 1'b1;
        if (o_ok)
        begin
            ocol_next     = o_eol ? '0 : cocol + 1'b1;
            orow_next     = o_eol ? corow + 1'b1 : corow;
            o_on_next     = !o_last;
            frame_on_next = !o_last;
        end

        tcnt_next = (ctcnt == d2) ? ctcnt : ctcnt + 1'b1;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_on_reg <= 1'b0;
            w_reg        <= '0;
            h_reg        <= '0;
            mode_reg     <= '0;
            icol_reg     <= '0;
            irow_reg     <= '0;
            mcol_reg     <= '0;
            mrow_reg     <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            in_done_reg  <= 1'b0;
            m_on_reg     <= 1'b0;
            o_on_reg     <= 1'b0;
            tcnt_reg     <= '0;
        end
        else if (tick)
        begin
            frame_on_reg <= frame_on_next;
            w_reg        <= cw;
            h_reg        <= ch;
            mode_reg     <= cmode;
            icol_reg     <= icol_next;
            irow_reg     <= irow_next;
            mcol_reg     <= mcol_next;
            mrow_reg     <= mrow_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            in_done_reg  <= in_done_next;
            m_on_reg     <= m_on_next;
            o_on_reg     <= o_on_next;
            tcnt_reg     <= tcnt_next;
        end
    end

    // token to the window pipeline
    always_comb
    begin
        push              = tick;
        tok.grey          = gsum[23:16];
        tok.tcol          = cicol;
        tok.mode          = cmode;
        tok.mid_bnd.top   = cmrow == '0;
        tok.mid_bnd.bot   = {1'b0, cmrow} == hm1;
        tok.mid_bnd.left  = cmcol == '0;
        tok.mid_bnd.right = m_eol;
        tok.out_bnd.top   = corow == '0;
        tok.out_bnd.bot   = {1'b0, corow} == hm1;
        tok.out_bnd.left  = cocol == '0;
        tok.out_bnd.right = o_eol;
        tok.out_ok        = o_ok;
        tok.last          = o_ok && o_last;
    end

endmodule

@@ rtl/mcf_queue.sv @@
module mcf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mcf_pkg::tok_t      push_tok,
    input  logic               pop,
    output mcf_pkg::tok_t      head,
    output mcf_pkg::q_stat_t   stat
);

    mcf_pkg::tok_t                 ent_reg [mcf_pkg::QUEUE_DEPTH];
    logic [mcf_pkg::QPTR_W-1:0]    wp_reg, rp_reg;
    logic [mcf_pkg::QPTR_W:0]      cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign stat.valid = cnt_reg != '0;
    assign stat.full  = cnt_reg == (mcf_pkg::QPTR_W+1)'(mcf_pkg::QUEUE_DEPTH);
    assign head       = ent_reg[rp_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push) wp_reg <= wp_reg + 1'b1;
            if (do_pop)  rp_reg <= rp_reg + 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) ent_reg[wp_reg] <= push_tok;
    end

endmodule

@@ rtl/mcf_back.sv @@
module mcf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mcf_pkg::tok_t      q_tok,
    input  logic               q_valid,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         grey_out,
    output logic               frame_last
);

    // line memories: grey rows, first-pass rows, delayed first-pass stats
    logic [15:0] grey_mem  [mcf_pkg::MAX_WIDTH];
    logic [15:0] pass_mem  [mcf_pkg::MAX_WIDTH];
    logic [23:0] stat_mem  [mcf_pkg::MAX_WIDTH];

    logic            en;
    logic            p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, out_v_reg;
    mcf_pkg::tok_t   p1_tok_reg, p2_tok_reg, p3_tok_reg, p4_tok_reg;
    logic [15:0]     rd1_reg, f1_data_reg, rd2_reg, f2_data_reg;
    logic [23:0]     rd3_reg, f3_data_reg, xlast_reg, p4_x_reg;
    logic            f1_hit_reg, f2_hit_reg, f3_hit_reg;
    logic [8:0][7:0] win1_reg, win2_reg;
    logic [7:0]      lo3_reg, hi3_reg, c3_reg, s3_reg;
    logic [7:0]      out_grey_reg;
    logic            out_last_reg;

    logic [15:0]     pair1, wr1_data, pair2, wr2_data;
    logic [23:0]     x_rd, wr3_data;
    logic [8:0]      m1, m2;
    logic [7:0]      lo1, hi1, lo2, hi2, res;
    logic [7:0]      p4_lo, p4_hi, p4_c;

    assign en    = !out_v_reg || !out_stall;
    assign q_pop = en;

    // stage 1: grey column with bypass of the write landing on the same edge
    assign pair1    = f1_hit_reg ? f1_data_reg : rd1_reg;
    assign wr1_data = {p1_tok_reg.grey, pair1[15:8]};

    // stage 2: first-pass window statistics
    assign m1  = mcf_pkg::win_mask(p2_tok_reg.mid_bnd);
    assign lo1 = mcf_pkg::win_lo(win1_reg, m1);
    assign hi1 = mcf_pkg::win_hi(win1_reg, m1);

    // stage 3: first-pass column and stat delay line
    assign pair2    = f2_hit_reg ? f2_data_reg : rd2_reg;
    assign wr2_data = {s3_reg, pair2[15:8]};
    assign x_rd     = f3_hit_reg ? f3_data_reg : rd3_reg;
    assign wr3_data = {lo3_reg, hi3_reg, c3_reg};

    // stage 4: second-pass statistics and mode select
    assign {p4_lo, p4_hi, p4_c} = p4_x_reg;
    assign m2  = mcf_pkg::win_mask(p4_tok_reg.out_bnd);
    assign lo2 = mcf_pkg::win_lo(win2_reg, m2);
    assign hi2 = mcf_pkg::win_hi(win2_reg, m2);

    always_comb
    begin
        case (p4_tok_reg.mode)
            mcf_pkg::MODE_BDILATE: res = (p4_lo == 8'd0) ? 8'd0 : 8'd255;
            mcf_pkg::MODE_BERODE:  res = (p4_hi == 8'd0) ? 8'd0 : 8'd255;
            mcf_pkg::MODE_MIN:     res = p4_lo;
            mcf_pkg::MODE_MAX:     res = p4_hi;
            mcf_pkg::MODE_OPEN:    res = lo2;
            mcf_pkg::MODE_CLOSE:   res = hi2;
            mcf_pkg::MODE_OUTER:   res = (p4_c != p4_hi) ? 8'd0 : 8'd255;
            mcf_pkg::MODE_INNER:   res = (p4_c != p4_lo) ? 8'd0 : 8'd255;
            default:               res = p4_c;
        endcase
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg  <= q_valid;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;
            out_v_reg <= p4_v_reg && p4_tok_reg.out_ok;
        end
    end

    // datapath and memories
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_valid)
            begin
                p1_tok_reg  <= q_tok;
                rd1_reg     <= grey_mem[q_tok.tcol];
                f1_hit_reg  <= p1_v_reg && (p1_tok_reg.tcol == q_tok.tcol);
                f1_data_reg <= wr1_data;
            end
            if (p1_v_reg)
            begin
                grey_mem[p1_tok_reg.tcol] <= wr1_data;
                for (int i = 0; i < 3; i++)
                begin
                    win1_reg[3*i]   <= win1_reg[3*i+1];
                    win1_reg[3*i+1] <= win1_reg[3*i+2];
                end
                win1_reg[2] <= pair1[7:0];
                win1_reg[5] <= pair1[15:8];
                win1_reg[8] <= p1_tok_reg.grey;
                p2_tok_reg  <= p1_tok_reg;
            end
            if (p2_v_reg)
            begin
                p3_tok_reg  <= p2_tok_reg;
                lo3_reg     <= lo1;
                hi3_reg     <= hi1;
                c3_reg      <= win1_reg[4];
                s3_reg      <= (p2_tok_reg.mode == mcf_pkg::MODE_OPEN) ? hi1 : lo1;
                rd2_reg     <= pass_mem[p2_tok_reg.tcol];
                rd3_reg     <= stat_mem[p2_tok_reg.tcol];
                f2_hit_reg  <= p3_v_reg && (p3_tok_reg.tcol == p2_tok_reg.tcol);
                f2_data_reg <= wr2_data;
                f3_hit_reg  <= p3_v_reg && (p3_tok_reg.tcol == p2_tok_reg.tcol);
                f3_data_reg <= wr3_data;
            end
            if (p3_v_reg)
            begin
                pass_mem[p3_tok_reg.tcol] <= wr2_data;
                stat_mem[p3_tok_reg.tcol] <= wr3_data;
                for (int i = 0; i < 3; i++)
                begin
                    win2_reg[3*i]   <= win2_reg[3*i+1];
                    win2_reg[3*i+1] <= win2_reg[3*i+2];
                end
                win2_reg[2] <= pair2[7:0];
                win2_reg[5] <= pair2[15:8];
                win2_reg[8] <= s3_reg;
                xlast_reg   <= x_rd;
                p4_x_reg    <= xlast_reg;
                p4_tok_reg  <= p3_tok_reg;
            end
            if (p4_v_reg)
            begin
                out_grey_reg <= res;
                out_last_reg <= p4_tok_reg.last;
            end
        end
    end

    assign out_valid  = out_v_reg;
    assign grey_out   = out_grey_reg;
    assign frame_last = out_last_reg;

endmodule

@@ rtl/morphology_3x3_filter.sv @@
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_stall    action, red, green, blue
// out      source     out_valid/out_stall  grey_out, frame_last
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock unless in_stall; results pass the queue and window pipeline.
// Output position o leaves on the tick of raster position o + 2*(width+1), so a
// frame drains with flush items after its last pixel.
// Reset clears the control state; the line memories are not cleared.
// out_stall freezes the window pipeline; a 4-entry queue absorbs input until full.
module morphology_3x3_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  grey_out,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    mcf_pkg::cfg_t     cfg_reg;
    mcf_pkg::tok_t     push_tok, head_tok;
    mcf_pkg::q_stat_t  q_stat;
    logic              push, pop, acc;

    assign cfg_ready = 1'b1;
    assign acc       = in_valid && !in_stall;
    assign in_stall  = q_stat.full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= mcf_pkg::SIZE_W'(mcf_pkg::MAX_WIDTH);
            cfg_reg.height <= mcf_pkg::SIZE_W'(mcf_pkg::MAX_HEIGHT);
            cfg_reg.mode   <= mcf_pkg::MODE_GREY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mcf_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_data;
                mcf_pkg::REG_HEIGHT: cfg_reg.height <= cfg_data;
                mcf_pkg::REG_MODE:   cfg_reg.mode   <= cfg_data[3:0];
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    mcf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (acc),
        .action (action),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .cfg    (cfg_reg),
        .push   (push),
        .tok    (push_tok)
    );

    mcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .head     (head_tok),
        .stat     (q_stat)
    );

    mcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_tok      (head_tok),
        .q_valid    (q_stat.valid),
        .q_pop      (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .grey_out   (grey_out),
        .frame_last (frame_last)
    );

    // a tick is only pushed while the queue has room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("tick pushed into full queue");

    // a pushed tick into an empty queue is visible next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_stat.valid) |=> q_stat.valid)
        else $error("pushed tick lost");

    // a tick only comes from an accepted transfer
    a_tick_acc: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> acc)
        else $error("tick without accepted item");

endmodule
